// ===== rtl/core/deadline_timer_task_queue_core_defines.svh =====
// assertion macros for the deadline timer task queue core
// no dependencies; included by the top level only
`ifndef DEADLINE_TIMER_TASK_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_TIMER_TASK_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DTTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define DTTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/dttq_pkg.sv =====
// shared types and codes for the deadline timer task queue core
// no dependencies
`default_nettype none

package dttq_pkg;

   localparam int TASK_SLOTS_DEF = 16;

   localparam int ACTION_W = 3;
   localparam int TIME_W   = 48;
   localparam int DELAY_W  = 40;
   localparam int ID_W     = 32;
   localparam int STATUS_W = 4;
   localparam int QCOUNT_W = 5;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_ONCE   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REPEAT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CANCEL = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POLL   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_FINISH = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_SCHEDULED    = 4'd0;
   localparam logic [STATUS_W-1:0] ST_FULL         = 4'd1;
   localparam logic [STATUS_W-1:0] ST_DISPATCHED   = 4'd2;
   localparam logic [STATUS_W-1:0] ST_NOTHING_DUE  = 4'd3;
   localparam logic [STATUS_W-1:0] ST_CANCELLED    = 4'd4;
   localparam logic [STATUS_W-1:0] ST_WILL_CANCEL  = 4'd5;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 4'd6;
   localparam logic [STATUS_W-1:0] ST_REQUEUED     = 4'd7;
   localparam logic [STATUS_W-1:0] ST_RETIRED      = 4'd8;
   localparam logic [STATUS_W-1:0] ST_BUSY         = 4'd9;
   localparam logic [STATUS_W-1:0] ST_NONE_RUNNING = 4'd10;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [TIME_W-1:0]   current_time;
      logic [DELAY_W-1:0]  first_delay_us;
      logic [DELAY_W-1:0]  delay_us;
      logic [ID_W-1:0]     target_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     task_id;
      logic [ID_W-1:0]     running_id;
      logic [QCOUNT_W-1:0] queued_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/deadline_timer_task_queue_core.sv =====
// top level of the deadline timer task queue: slot table, scan sequencer, shared adder
// depends on dttq_pkg and deadline_timer_task_queue_core_defines.svh
`default_nettype none

`include "deadline_timer_task_queue_core_defines.svh"

// Deadline-ordered timer task queue. TASK_SLOTS slots each hold a task id, a 48-bit
// deadline, a 40-bit period and a one-shot flag in a single-port-write, registered-read
// slot memory; the occupancy bits live in flops. One request beat is taken at a time.
// Schedule, cancel and poll walk the slot memory one slot per cycle, and one shared
// 49-bit adder/subtractor does the due test and earliest-deadline compare while
// scanning and the saturating deadline sum at commit. Schedule, cancel and poll answer
// after the full slot walk; finish fetches the running slot first, and requests
// answered straight away (busy, none running, cancel of the running task, unknown
// action) go from decode to the response. A finished response beat sits in an
// output register, so the next request is taken while it waits. Slot contents
// need no clearing after reset: only slots whose occupancy bit is set are ever
// looked at.
module deadline_timer_task_queue_core
   import dttq_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CW = $clog2(TASK_SLOTS + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(TASK_SLOTS - 1);

   typedef struct packed {
      logic               one_shot;
      logic [DELAY_W-1:0] period;
      logic [TIME_W-1:0]  deadline;
      logic [ID_W-1:0]    task_id;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_FETCH,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      OP_SCHED,
      OP_CANCEL,
      OP_POLL,
      OP_FINISH,
      OP_MARK,
      OP_FIXED
   } op_type;

   // slot memory
   entry_type mem [TASK_SLOTS];
   entry_type rd_ff;
   logic [IW-1:0] rd_addr;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;

   // control and sequencer state
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   req_type   req_ff, req_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  running_valid_ff, running_valid_in;
   logic [IW-1:0]         running_slot_ff, running_slot_in;
   logic                  running_cancelled_ff, running_cancelled_in;
   logic [ID_W-1:0]       running_id_ff, running_id_in;
   logic [ID_W-1:0]       last_id_ff, last_id_in;

   // scan pipeline: address issue, then evaluation of the registered read
   logic [IW-1:0]     scan_idx_ff, scan_idx_in;
   logic              issue_ff, issue_in;
   logic              pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0]     pipe_idx_ff, pipe_idx_in;
   logic              found_ff, found_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_dl_ff, best_dl_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // shared adder/subtractor
   logic              alu_sub;
   logic [TIME_W-1:0] alu_a, alu_b, alu_b_eff;
   logic [TIME_W:0]   alu_sum;
   logic              alu_ge;
   logic [TIME_W-1:0] alu_sat;

   logic [ID_W-1:0]     next_id;
   logic                cand;
   logic [STATUS_W-1:0] resp_status;
   logic [ID_W-1:0]     resp_tid;

   assign alu_b_eff = alu_sub ? ~alu_b : alu_b;
   assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b_eff} + {{TIME_W{1'b0}}, alu_sub};
   assign alu_ge    = alu_sum[TIME_W];
   // carry out of an add means the deadline overflowed, so pin it at the top
   assign alu_sat   = alu_sum[TIME_W] ? {TIME_W{1'b1}} : alu_sum[TIME_W-1:0];

   // ids wrap back to 1, never 0
   assign next_id = (last_id_ff == {ID_W{1'b1}}) ? {{(ID_W-1){1'b0}}, 1'b1}
                                                 : last_id_ff + {{(ID_W-1){1'b0}}, 1'b1};

   assign rd_addr   = (state_ff == S_SCAN) ? scan_idx_ff : running_slot_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // shared unit operands
   always_comb begin
      alu_sub = 1'b0;
      alu_a   = req_ff.current_time;
      alu_b   = {{(TIME_W-DELAY_W){1'b0}}, req_ff.first_delay_us};
      if (state_ff == S_SCAN) begin
         alu_sub = 1'b1;
         if (found_ff) begin
            // earlier than the best so far (strict, so ties keep the lower slot)
            alu_a = rd_ff.deadline;
            alu_b = best_dl_ff;
         end else begin
            // due test: now >= deadline
            alu_a = req_ff.current_time;
            alu_b = rd_ff.deadline;
         end
      end else if (op_ff == OP_FINISH) begin
         alu_b = {{(TIME_W-DELAY_W){1'b0}}, rd_ff.period};
      end else if (req_ff.action == ACT_ONCE) begin
         alu_b = {{(TIME_W-DELAY_W){1'b0}}, req_ff.delay_us};
      end
   end

   // candidate test for the slot whose read data is at hand
   always_comb begin
      cand = 1'b0;
      case (op_ff)
         OP_SCHED: begin
            cand = !valid_ff[pipe_idx_ff] && !found_ff;
         end
         OP_CANCEL: begin
            cand = valid_ff[pipe_idx_ff] && !found_ff
                   && !(running_valid_ff && (pipe_idx_ff == running_slot_ff))
                   && (rd_ff.task_id == req_ff.target_id);
         end
         OP_POLL: begin
            cand = valid_ff[pipe_idx_ff] && (found_ff ? !alu_ge : alu_ge);
         end
         default: begin
            cand = 1'b0;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in             = state_ff;
      op_in                = op_ff;
      req_in               = req_ff;
      status_in            = status_ff;
      valid_in             = valid_ff;
      count_in             = count_ff;
      running_valid_in     = running_valid_ff;
      running_slot_in      = running_slot_ff;
      running_cancelled_in = running_cancelled_ff;
      running_id_in        = running_id_ff;
      last_id_in           = last_id_ff;
      scan_idx_in          = scan_idx_ff;
      issue_in             = issue_ff;
      pipe_vld_in          = 1'b0;
      pipe_idx_in          = pipe_idx_ff;
      found_in             = found_ff;
      best_idx_in          = best_idx_ff;
      best_dl_in           = best_dl_ff;
      best_id_in           = best_id_ff;
      rsp_valid_in         = rsp_valid_ff;
      rsp_in               = rsp_ff;
      mem_we               = 1'b0;
      mem_waddr            = best_idx_ff;
      mem_wdata            = rd_ff;
      resp_status          = status_ff;
      resp_tid             = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            found_in    = 1'b0;
            scan_idx_in = '0;
            issue_in    = 1'b1;
            case (req_ff.action)
               ACT_ONCE, ACT_REPEAT: begin
                  op_in    = OP_SCHED;
                  state_in = S_SCAN;
               end
               ACT_CANCEL: begin
                  if (running_valid_ff && (running_id_ff == req_ff.target_id)) begin
                     op_in     = OP_MARK;
                     status_in = ST_WILL_CANCEL;
                     state_in  = S_RESP;
                  end else begin
                     op_in    = OP_CANCEL;
                     state_in = S_SCAN;
                  end
               end
               ACT_POLL: begin
                  if (running_valid_ff) begin
                     op_in     = OP_FIXED;
                     status_in = ST_BUSY;
                     state_in  = S_RESP;
                  end else begin
                     op_in    = OP_POLL;
                     state_in = S_SCAN;
                  end
               end
               ACT_FINISH: begin
                  if (!running_valid_ff) begin
                     op_in     = OP_FIXED;
                     status_in = ST_NONE_RUNNING;
                     state_in  = S_RESP;
                  end else begin
                     op_in    = OP_FINISH;
                     state_in = S_FETCH;
                  end
               end
               default: begin
                  op_in     = OP_FIXED;
                  status_in = ST_NOTHING_DUE;
                  state_in  = S_RESP;
               end
            endcase
         end

         S_SCAN: begin
            // issue the next slot read
            if (issue_ff) begin
               pipe_vld_in = 1'b1;
               pipe_idx_in = scan_idx_ff;
               if (scan_idx_ff == LAST_SLOT) begin
                  issue_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + {{(IW-1){1'b0}}, 1'b1};
               end
            end
            // evaluate the slot read last cycle
            if (pipe_vld_ff) begin
               if (cand) begin
                  found_in    = 1'b1;
                  best_idx_in = pipe_idx_ff;
                  best_dl_in  = rd_ff.deadline;
                  best_id_in  = rd_ff.task_id;
               end
               if (pipe_idx_ff == LAST_SLOT) begin
                  state_in = S_RESP;
               end
            end
         end

         S_FETCH: begin
            // running slot read lands in rd_ff
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               case (op_ff)
                  OP_SCHED: begin
                     if (found_ff) begin
                        mem_we             = 1'b1;
                        mem_waddr          = best_idx_ff;
                        mem_wdata.task_id  = next_id;
                        mem_wdata.deadline = alu_sat;
                        mem_wdata.one_shot = (req_ff.action == ACT_ONCE);
                        mem_wdata.period   = (req_ff.action == ACT_ONCE) ? '0
                                                                         : req_ff.delay_us;
                        valid_in[best_idx_ff] = 1'b1;
                        count_in   = count_ff + {{(CW-1){1'b0}}, 1'b1};
                        last_id_in = next_id;
                        resp_status = ST_SCHEDULED;
                        resp_tid    = next_id;
                     end else begin
                        resp_status = ST_FULL;
                     end
                  end
                  OP_CANCEL: begin
                     if (found_ff) begin
                        valid_in[best_idx_ff] = 1'b0;
                        count_in    = count_ff - {{(CW-1){1'b0}}, 1'b1};
                        resp_status = ST_CANCELLED;
                     end else begin
                        resp_status = ST_NOT_FOUND;
                     end
                  end
                  OP_POLL: begin
                     if (found_ff) begin
                        running_valid_in     = 1'b1;
                        running_slot_in      = best_idx_ff;
                        running_cancelled_in = 1'b0;
                        running_id_in        = best_id_ff;
                        resp_status          = ST_DISPATCHED;
                        resp_tid             = best_id_ff;
                     end else begin
                        resp_status = ST_NOTHING_DUE;
                     end
                  end
                  OP_FINISH: begin
                     resp_tid = running_id_ff;
                     if (rd_ff.one_shot || running_cancelled_ff) begin
                        valid_in[running_slot_ff] = 1'b0;
                        count_in    = count_ff - {{(CW-1){1'b0}}, 1'b1};
                        resp_status = ST_RETIRED;
                     end else begin
                        mem_we             = 1'b1;
                        mem_waddr          = running_slot_ff;
                        mem_wdata          = rd_ff;
                        mem_wdata.deadline = alu_sat;
                        resp_status        = ST_REQUEUED;
                     end
                     running_valid_in     = 1'b0;
                     running_slot_in      = '0;
                     running_cancelled_in = 1'b0;
                     running_id_in        = '0;
                  end
                  OP_MARK: begin
                     running_cancelled_in = 1'b1;
                  end
                  default: begin
                     resp_status = status_ff;
                  end
               endcase
               rsp_valid_in        = 1'b1;
               rsp_in.status       = resp_status;
               rsp_in.task_id      = resp_tid;
               rsp_in.running_id   = running_id_in;
               rsp_in.queued_count = QCOUNT_W'(count_in);
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // slot memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[rd_addr];
   end

   // sequencer registers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_IDLE;
         op_ff                <= OP_FIXED;
         status_ff            <= ST_NOTHING_DUE;
         valid_ff             <= '0;
         count_ff             <= '0;
         running_valid_ff     <= 1'b0;
         running_slot_ff      <= '0;
         running_cancelled_ff <= 1'b0;
         running_id_ff        <= '0;
         last_id_ff           <= '0;
         issue_ff             <= 1'b0;
         pipe_vld_ff          <= 1'b0;
         found_ff             <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff             <= state_in;
         op_ff                <= op_in;
         status_ff            <= status_in;
         valid_ff             <= valid_in;
         count_ff             <= count_in;
         running_valid_ff     <= running_valid_in;
         running_slot_ff      <= running_slot_in;
         running_cancelled_ff <= running_cancelled_in;
         running_id_ff        <= running_id_in;
         last_id_ff           <= last_id_in;
         issue_ff             <= issue_in;
         pipe_vld_ff          <= pipe_vld_in;
         found_ff             <= found_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
      req_ff      <= req_in;
      scan_idx_ff <= scan_idx_in;
      pipe_idx_ff <= pipe_idx_in;
      best_idx_ff <= best_idx_in;
      best_dl_ff  <= best_dl_in;
      best_id_ff  <= best_id_in;
      rsp_ff      <= rsp_in;
   end

   // occupancy counter tracks the occupancy bits
   `DTTQ_ASSERT_NOW(a_count_matches, clock, reset, 1'b1, $countones(valid_ff) == count_ff, "occupancy count out of step with slot bits")

   // a dispatched task keeps its slot
   `DTTQ_ASSERT_NOW(a_running_slot_held, clock, reset, running_valid_ff, valid_ff[running_slot_ff], "running task has no occupied slot")

   // ids are never zero, so the running id doubles as the running flag
   `DTTQ_ASSERT_NOW(a_running_id, clock, reset, 1'b1, running_valid_ff == (running_id_ff != '0), "running id disagrees with running flag")

   // one request at a time: no second beat straight after a taken one
   `DTTQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while previous one still in work")

endmodule

`default_nettype wire
